FILE: rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// shared types, codes and utf-8 helpers of the json string unescaper
// ----------------------------------------------------------------------------
package jsu_pkg;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [1:0] KIND_BYTE   = 2'd0;
	localparam logic [1:0] KIND_CODE   = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_CTRL     = 3'd1;
	localparam logic [2:0] ERR_ESC      = 3'd2;
	localparam logic [2:0] ERR_HEX      = 3'd3;
	localparam logic [2:0] ERR_EOS      = 3'd4;
	localparam logic [2:0] ERR_LONE_LOW = 3'd5;
	localparam logic [2:0] ERR_MISS_LOW = 3'd6;

	typedef struct packed {
		logic [1:0]  kind;
		logic [20:0] value;
		logic        string_end;
		logic [2:0]  error_code;
	} cmd_t;

	// index of the final utf-8 byte of a code point
	function automatic logic [1:0] utf8_last(input logic [20:0] cp);
		logic [1:0] n;
		if (cp <= 21'h7F) begin
			n = 2'd0;
		end else if (cp <= 21'h7FF) begin
			n = 2'd1;
		end else if (cp <= 21'hFFFF) begin
			n = 2'd2;
		end else begin
			n = 2'd3;
		end
		return n;
	endfunction

	function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] idx);
		logic [7:0] b;
		b = 8'h00;
		unique case (utf8_last(cp))
			2'd0: b = cp[7:0];
			2'd1: begin
				if (idx == 2'd0) b = {3'b110, cp[10:6]};
				else b = {2'b10, cp[5:0]};
			end
			2'd2: begin
				unique case (idx)
					2'd0: b = {4'b1110, cp[15:12]};
					2'd1: b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			default: begin
				unique case (idx)
					2'd0: b = {5'b11110, cp[20:18]};
					2'd1: b = {2'b10, cp[17:12]};
					2'd2: b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
		endcase
		return b;
	endfunction

	// {not a hex digit, digit value}
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = {1'b0, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = {1'b0, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = {1'b0, 4'(c - 8'h37)};
		end else begin
			v = 5'h10;
		end
		return v;
	endfunction

endpackage

FILE: rtl/jsu_if.sv
// ----------------------------------------------------------------------------
// jsu_if
// valid/ready channels of the json string unescaper
// ----------------------------------------------------------------------------
interface jsu_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface jsu_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       last;
	logic       string_end;
	logic [2:0] error_code;

	modport source (output valid, output out_byte, output byte_valid, output last,
		output string_end, output error_code, input ready);
	modport sink (input valid, input out_byte, input byte_valid, input last,
		input string_end, input error_code, output ready);
endinterface

FILE: rtl/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// takes raw string bytes, tracks escapes and hex groups, queues one command
// ----------------------------------------------------------------------------
module jsu_front (
	input  logic              clk,
	input  logic              arst_n,
	jsu_byte_if.sink          raw,
	input  logic              full,
	output logic              push,
	output jsu_pkg::cmd_t     push_cmd
);

	localparam logic [3:0] M_NORMAL  = 4'd0;
	localparam logic [3:0] M_ESC     = 4'd1;
	localparam logic [3:0] M_HEX1    = 4'd2;
	localparam logic [3:0] M_HEX4    = 4'd5;
	localparam logic [3:0] M_WANT_BS = 4'd6;
	localparam logic [3:0] M_WANT_U  = 4'd7;
	localparam logic [3:0] M_LOW1    = 4'd8;
	localparam logic [3:0] M_LOW4    = 4'd11;

	logic [3:0]  mode_q, mode_d;
	logic [9:0]  high_q, high_d;
	logic [15:0] acc_q, acc_d;
	logic        bad_q, bad_d;

	logic        accept;
	logic [7:0]  c;
	logic [4:0]  hv;
	logic [15:0] acc_n;
	logic        bad_n;
	logic        in_first, in_low;

	assign raw.ready = !full;
	assign accept    = raw.valid && !full;
	assign c         = raw.in_byte;
	assign hv        = jsu_pkg::hex_value(c);
	assign acc_n     = {acc_q[11:0], hv[4] ? 4'd0 : hv[3:0]};
	assign bad_n     = bad_q || hv[4];
	assign in_first  = (mode_q >= M_HEX1) && (mode_q <= M_HEX4);
	assign in_low    = (mode_q >= M_LOW1) && (mode_q <= M_LOW4);

	always_comb begin
		mode_d   = mode_q;
		high_d   = high_q;
		acc_d    = acc_q;
		bad_d    = bad_q;
		push     = 1'b0;
		push_cmd = '{kind: jsu_pkg::KIND_STATUS, value: 21'd0, string_end: 1'b0,
			error_code: jsu_pkg::ERR_NONE};
		if (accept) begin
			priority if (mode_q == M_ESC) begin
				push          = 1'b1;
				mode_d        = M_NORMAL;
				push_cmd.kind = jsu_pkg::KIND_BYTE;
				unique case (c)
					8'h62: push_cmd.value = 21'h08;
					8'h66: push_cmd.value = 21'h0C;
					8'h6E: push_cmd.value = 21'h0A;
					8'h72: push_cmd.value = 21'h0D;
					8'h74: push_cmd.value = 21'h09;
					8'h22: push_cmd.value = 21'h22;
					8'h5C: push_cmd.value = 21'h5C;
					8'h2F: push_cmd.value = 21'h2F;
					8'h75: begin
						push   = 1'b0;
						mode_d = M_HEX1;
						acc_d  = 16'd0;
						bad_d  = 1'b0;
					end
					default: begin
						push_cmd.kind       = jsu_pkg::KIND_STATUS;
						push_cmd.error_code = jsu_pkg::ERR_ESC;
					end
				endcase
			end else if (in_first || in_low) begin
				priority if (c == 8'h00) begin
					push                = 1'b1;
					push_cmd.error_code = jsu_pkg::ERR_EOS;
					mode_d              = M_NORMAL;
				end else if (mode_q != M_HEX4 && mode_q != M_LOW4) begin
					mode_d = mode_q + 4'd1;
					acc_d  = acc_n;
					bad_d  = bad_n;
				end else if (bad_n) begin
					push                = 1'b1;
					push_cmd.error_code = jsu_pkg::ERR_HEX;
					mode_d              = M_NORMAL;
				end else if (in_first) begin
					mode_d = M_NORMAL;
					priority if (acc_n >= 16'hDC00 && acc_n <= 16'hDFFF) begin
						push                = 1'b1;
						push_cmd.error_code = jsu_pkg::ERR_LONE_LOW;
					end else if (acc_n >= 16'hD800 && acc_n <= 16'hDBFF) begin
						high_d = acc_n[9:0];
						mode_d = M_WANT_BS;
					end else begin
						push           = 1'b1;
						push_cmd.kind  = jsu_pkg::KIND_CODE;
						push_cmd.value = {5'd0, acc_n};
					end
				end else begin
					push   = 1'b1;
					mode_d = M_NORMAL;
					if (acc_n >= 16'hDC00 && acc_n <= 16'hDFFF) begin
						push_cmd.kind  = jsu_pkg::KIND_CODE;
						push_cmd.value = {1'b0, high_q, acc_n[9:0]} + 21'h10000;
					end else begin
						push_cmd.error_code = jsu_pkg::ERR_MISS_LOW;
					end
				end
			end else if (mode_q == M_WANT_BS) begin
				if (c == 8'h5C) begin
					mode_d = M_WANT_U;
				end else begin
					push                = 1'b1;
					push_cmd.error_code = jsu_pkg::ERR_MISS_LOW;
					mode_d              = M_NORMAL;
				end
			end else if (mode_q == M_WANT_U) begin
				if (c == 8'h75) begin
					mode_d = M_LOW1;
					acc_d  = 16'd0;
					bad_d  = 1'b0;
				end else begin
					push                = 1'b1;
					push_cmd.error_code = jsu_pkg::ERR_MISS_LOW;
					mode_d              = M_NORMAL;
				end
			end else begin
				mode_d = M_NORMAL;
				priority if (c == 8'h22) begin
					push                = 1'b1;
					push_cmd.string_end = 1'b1;
				end else if (c < 8'h20) begin
					push                = 1'b1;
					push_cmd.error_code = jsu_pkg::ERR_CTRL;
				end else if (c == 8'h5C) begin
					mode_d = M_ESC;
				end else begin
					push           = 1'b1;
					push_cmd.kind  = jsu_pkg::KIND_BYTE;
					push_cmd.value = {13'd0, c};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_NORMAL;
			high_q <= '0;
			acc_q  <= '0;
			bad_q  <= 1'b0;
		end else begin
			mode_q <= mode_d;
			high_q <= high_d;
			acc_q  <= acc_d;
			bad_q  <= bad_d;
		end
	end

endmodule

FILE: rtl/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module jsu_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  jsu_pkg::cmd_t push_cmd,
	input  logic          pop,
	output jsu_pkg::cmd_t head,
	output logic          empty,
	output logic          full
);

	jsu_pkg::cmd_t                 mem_q [jsu_pkg::QDEPTH];
	logic [jsu_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [jsu_pkg::QCNT_W-1:0]    count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == jsu_pkg::QCNT_W'(jsu_pkg::QDEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// expands queued commands into result beats, utf-8 bytes one per beat
// ----------------------------------------------------------------------------
module jsu_back (
	input  logic          clk,
	input  logic          arst_n,
	input  jsu_pkg::cmd_t head,
	input  logic          empty,
	output logic          pop,
	jsu_result_if.source  dec
);

	logic [1:0] idx_q;
	logic [1:0] last_idx;
	logic       is_last;
	logic       fire;

	always_comb begin
		last_idx       = 2'd0;
		dec.out_byte   = 8'h00;
		dec.byte_valid = 1'b0;
		unique case (head.kind)
			jsu_pkg::KIND_BYTE: begin
				dec.out_byte   = head.value[7:0];
				dec.byte_valid = 1'b1;
			end
			jsu_pkg::KIND_CODE: begin
				last_idx       = jsu_pkg::utf8_last(head.value);
				dec.out_byte   = jsu_pkg::utf8_byte(head.value, idx_q);
				dec.byte_valid = 1'b1;
			end
			default: begin
				dec.out_byte   = 8'h00;
				dec.byte_valid = 1'b0;
			end
		endcase
	end

	assign is_last        = (idx_q == last_idx);
	assign dec.valid      = !empty;
	assign dec.last       = is_last;
	assign dec.string_end = head.string_end;
	assign dec.error_code = head.error_code;
	assign fire           = dec.valid && dec.ready;
	assign pop            = fire && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (fire) begin
			idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

FILE: rtl/json_string_unescape.sv
// ----------------------------------------------------------------------------
// json_string_unescape
// streaming decoder of a json string body into utf-8 bytes
// ----------------------------------------------------------------------------
// raw: one string-body byte per beat, starting after the opening quote.
// dec: one result per beat; a data byte (byte_valid 1) or a status beat
//   (byte_valid 0) for the closing quote or an error. last marks the final
//   beat caused by one raw byte. after a status the next byte starts a new
//   string body.
// a result reaches dec through the command queue, which holds it in a register.
// throughput: one raw byte per cycle and one result per cycle while dec is ready;
//   a code point of n utf-8 bytes occupies dec for n beats.
// the front takes a byte in every cycle that the four-entry command queue
//   is not full; a stalled dec fills the queue, then raw.ready drops.
// reset: empties the queue and returns to plain character mode.
// ----------------------------------------------------------------------------
module json_string_unescape (
	input  logic         clk,
	input  logic         arst_n,
	jsu_byte_if.sink     raw,
	jsu_result_if.source dec
);

	logic          push;
	logic          pop;
	logic          empty;
	logic          full;
	jsu_pkg::cmd_t push_cmd;
	jsu_pkg::cmd_t head;

	jsu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.raw      (raw),
		.full     (full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	jsu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	jsu_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.dec    (dec)
	);

endmodule

FILE: rtl/jsu_checker.sv
// ----------------------------------------------------------------------------
// jsu_checker
// port-level checks of the json string unescaper result stream
// ----------------------------------------------------------------------------
module jsu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       byte_valid,
	input logic       last,
	input logic       string_end,
	input logic [2:0] error_code
);

	// status beat is a lone zero beat that ends the string or reports an error
	a_status_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !byte_valid) |-> (out_byte == 8'h00 && last &&
			(string_end || error_code != jsu_pkg::ERR_NONE)))
		else $error("status beat malformed");

	// data beat carries no status
	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && byte_valid) |-> (!string_end && error_code == jsu_pkg::ERR_NONE))
		else $error("data beat carries status");

	// closing quote is never an error
	a_end_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && string_end) |-> (error_code == jsu_pkg::ERR_NONE))
		else $error("end of string with error");

	// stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_byte) &&
			$stable(last) && $stable(error_code)))
		else $error("stalled beat changed");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (dec.valid),
	.out_ready  (dec.ready),
	.out_byte   (dec.out_byte),
	.byte_valid (dec.byte_valid),
	.last       (dec.last),
	.string_end (dec.string_end),
	.error_code (dec.error_code)
);
